FILE: rtl/hex_keypad_press_with_repeat_assert.svh
// Assertion macros for the keypad qualifier.
// Depends on clk_i and rst_ni being visible in the module that expands them.
`ifndef HEX_KEYPAD_PRESS_WITH_REPEAT_ASSERT_SVH
`define HEX_KEYPAD_PRESS_WITH_REPEAT_ASSERT_SVH

`ifndef SYNTHESIS
`define HKP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hkp: same-cycle check failed");
`define HKP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hkp: next-cycle check failed");
`else
`define HKP_ASSERT_IMP(lbl, ante, cons)
`define HKP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/hkp_pkg.sv
// Shared types, constants and helpers for the keypad qualifier.
// No dependencies.
package hkp_pkg;

  localparam int NumKeys   = 16;
  localparam int KeyIdxW   = 4;
  localparam int RawW      = 16;
  localparam int HeldW     = 16;
  localparam int TickW     = 32;
  localparam int DelayW    = 8;
  localparam int NumCfgRegs = 2;
  localparam int CfgIdxW   = $clog2(NumCfgRegs);

  localparam logic [DelayW-1:0] InitDelayRst = DelayW'(20);
  localparam logic [DelayW-1:0] RepDelayRst  = DelayW'(5);

  localparam logic [CfgIdxW-1:0] RegInitialDelay = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRepeatDelay  = CfgIdxW'(1);

  localparam logic FuncSample = 1'b0;
  localparam logic FuncPoll   = 1'b1;

  typedef struct packed {
    logic [DelayW-1:0] initial_delay;
    logic [DelayW-1:0] repeat_delay;
  } hkp_cfg_t;

  typedef struct packed {
    logic             func;
    logic [RawW-1:0]  raw_keys;
    logic [TickW-1:0] tick;
  } hkp_item_t;

  typedef struct packed {
    logic               pressed;
    logic [KeyIdxW-1:0] key_index;
    logic [HeldW-1:0]   held_mask;
  } hkp_result_t;

  function automatic logic [KeyIdxW-1:0] lowest_index(input logic [NumKeys-1:0] v);
    logic [KeyIdxW-1:0] idx;
    idx = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = KeyIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/hkp_ifs.sv
// Valid/ready channel interfaces for the keypad qualifier.
// Depends on nothing; widths match hkp_pkg.
interface hkp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] raw_keys;
  logic [31:0] tick;

  modport source (output valid, func, raw_keys, tick, input ready);
  modport sink   (input valid, func, raw_keys, tick, output ready);
endinterface

interface hkp_out_if;
  logic        valid;
  logic        ready;
  logic        pressed;
  logic [3:0]  key_index;
  logic [15:0] held_mask;

  modport source (output valid, pressed, key_index, held_mask, input ready);
  modport sink   (input valid, pressed, key_index, held_mask, output ready);
endinterface

FILE: rtl/hkp_cfg_regs.sv
// Delay configuration registers for the keypad qualifier.
// Depends on hkp_pkg.
module hkp_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hkp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hkp_pkg::DelayW-1:0]  cfg_data_i,
  output hkp_pkg::hkp_cfg_t         cfg_o
);
  import hkp_pkg::*;

  hkp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_delay <= InitDelayRst;
      cfg_q.repeat_delay  <= RepDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegInitialDelay: cfg_q.initial_delay <= cfg_data_i;
        RegRepeatDelay:  cfg_q.repeat_delay  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/hkp_engine.sv
// Key state registers and the single-pass sample/poll update logic.
// Depends on hkp_pkg.
module hkp_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hkp_pkg::hkp_cfg_t    cfg_i,
  input  logic                 step_i,
  input  hkp_pkg::hkp_item_t   item_i,
  output hkp_pkg::hkp_result_t res_o
);
  import hkp_pkg::*;

  logic [NumKeys-1:0] prev_q, prev_d, cur_q, cur_d, lock_q, lock_d, rpt_q, rpt_d;
  logic [TickW-1:0]   last_q, last_d;
  logic [DelayW-1:0]  span_q, span_d;

  logic [TickW-1:0]   deadline;
  logic               passed;
  logic [NumKeys-1:0] raw, prev_exp, fresh, diff, chosen;

  assign deadline = last_q + TickW'(span_q);
  assign passed   = item_i.tick >= deadline;
  assign raw      = item_i.raw_keys[NumKeys-1:0];
  assign prev_exp = passed ? (prev_q & ~rpt_q) : prev_q;
  assign fresh    = cur_q & ~prev_exp;
  assign diff     = fresh & ~rpt_q;
  assign chosen   = (diff != '0) ? diff : rpt_q;

  always_comb begin
    prev_d = prev_q;
    cur_d  = cur_q;
    lock_d = lock_q;
    rpt_d  = rpt_q;
    last_d = last_q;
    span_d = span_q;
    res_o.pressed   = 1'b0;
    res_o.key_index = '0;
    unique case (item_i.func)
      FuncSample: begin
        prev_d = cur_q;
        cur_d  = raw;
        lock_d = lock_q & ~(cur_q ^ raw);
        rpt_d  = rpt_q & lock_d;
      end
      FuncPoll: begin
        prev_d = prev_exp;
        if (fresh != '0) begin
          lock_d = lock_q | chosen;
          last_d = item_i.tick;
          span_d = (chosen != rpt_q) ? cfg_i.initial_delay : cfg_i.repeat_delay;
          rpt_d  = chosen & (~chosen + NumKeys'(1));
          res_o.pressed   = 1'b1;
          res_o.key_index = lowest_index(rpt_d);
        end
      end
      default: ;
    endcase
    res_o.held_mask = HeldW'(cur_d & ~lock_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cur_q  <= '0;
      lock_q <= '0;
      rpt_q  <= '0;
      last_q <= '0;
      span_q <= '0;
    end else if (step_i) begin
      prev_q <= prev_d;
      cur_q  <= cur_d;
      lock_q <= lock_d;
      rpt_q  <= rpt_d;
      last_q <= last_d;
      span_q <= span_d;
    end
  end

endmodule

FILE: rtl/hex_keypad_press_with_repeat.sv
// Top level of the hex keypad press qualifier with auto-repeat.
// Depends on hkp_pkg, hkp_ifs, hkp_cfg_regs, hkp_engine and the assertion header.
//
//   channel  | dir | fields                      | words
//   in_i     | in  | func, raw_keys, tick        | one per item
//   out_o    | out | pressed, key_index, held_mask| one per item
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i | register writes
//
// Each word passes from acceptance to result through the input register, then
// the state update and result register; one word per cycle while out_o is ready.
// Reset clears the key masks, tick stamp and span, and loads the default delays.
// A stalled result holds while the input register still takes one more word.
`include "hex_keypad_press_with_repeat_assert.svh"

module hex_keypad_press_with_repeat (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hkp_in_if.sink                      in_i,
  hkp_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [hkp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hkp_pkg::DelayW-1:0]  cfg_data_i
);
  import hkp_pkg::*;

  hkp_cfg_t    cfg;
  hkp_item_t   item_q;
  hkp_result_t res_d, res_q;
  logic        in_vld_q, out_vld_q, advance;

  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;

  hkp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hkp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func     <= in_i.func;
      item_q.raw_keys <= in_i.raw_keys;
      item_q.tick     <= in_i.tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.pressed   = res_q.pressed;
  assign out_o.key_index = res_q.key_index;
  assign out_o.held_mask = res_q.held_mask;

  `HKP_ASSERT_IMP(a_ready_when_out_free, !out_vld_q, in_i.ready)
  `HKP_ASSERT_IMP(a_pressed_key_locked, out_vld_q && res_q.pressed, !res_q.held_mask[res_q.key_index])
  `HKP_ASSERT_NEXT(a_sample_quiet, advance && (item_q.func == FuncSample), out_vld_q && !res_q.pressed && (res_q.key_index == '0))

endmodule

FILE: verif/hkp_keypad_checker.sv
// Checker for the hex keypad press qualifier: predicts every result word from
// the accepted input words and register writes, then compares them in order.
// Depends on hkp_pkg and the channel interfaces in hkp_ifs.
module hkp_keypad_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hkp_in_if                           in_mon,
  hkp_out_if                          out_mon,
  input  logic                        cfg_we_i,
  input  logic [hkp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hkp_pkg::DelayW-1:0]  cfg_data_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          presses_o,
  output int                          repeats_o
);
  import hkp_pkg::*;

  logic [DelayW-1:0]  delay_first;
  logic [DelayW-1:0]  delay_again;
  logic [NumKeys-1:0] keys_prev;
  logic [NumKeys-1:0] keys_now;
  logic [NumKeys-1:0] keys_lock;
  logic [NumKeys-1:0] rep_key;
  logic [TickW-1:0]   press_stamp;
  logic [DelayW-1:0]  armed_span;

  hkp_result_t due_results[$];
  int          results_seen;

  task automatic advance_keypad(input hkp_item_t w, output hkp_result_t r);
    logic [TickW-1:0]   due_tick;
    logic [NumKeys-1:0] fresh;
    logic [NumKeys-1:0] picked;
    r = '0;
    if (w.func == FuncSample) begin
      keys_prev = keys_now;
      keys_now  = w.raw_keys[NumKeys-1:0];
      keys_lock &= ~(keys_prev ^ keys_now);
      rep_key   &= keys_lock;
    end else begin
      due_tick = press_stamp + TickW'(armed_span);
      if (w.tick >= due_tick) begin
        keys_prev &= ~rep_key;
      end
      fresh = keys_now & ~keys_prev;
      if (fresh != '0) begin
        picked = ((fresh & ~rep_key) != '0) ? (fresh & ~rep_key) : rep_key;
        keys_lock  |= picked;
        press_stamp = w.tick;
        if (picked != rep_key) begin
          armed_span = delay_first;
          presses_o++;
        end else begin
          armed_span = delay_again;
          repeats_o++;
        end
        rep_key     = picked & (~picked + 1'b1);
        r.pressed   = 1'b1;
        r.key_index = KeyIdxW'($clog2(rep_key));
      end
    end
    r.held_mask = keys_now & ~keys_lock;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hkp_item_t   w;
    hkp_result_t want;
    hkp_result_t got;
    if (!rst_ni) begin
      delay_first  = InitDelayRst;
      delay_again  = RepDelayRst;
      keys_prev    = '0;
      keys_now     = '0;
      keys_lock    = '0;
      rep_key      = '0;
      press_stamp  = '0;
      armed_span   = '0;
      due_results.delete();
      results_seen = 0;
      errors_o     = 0;
      pending_o    = 0;
      presses_o    = 0;
      repeats_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegInitialDelay: delay_first = cfg_data_i;
          RegRepeatDelay:  delay_again = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        w.func     = in_mon.func;
        w.raw_keys = in_mon.raw_keys;
        w.tick     = in_mon.tick;
        advance_keypad(w, want);
        due_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.pressed   = out_mon.pressed;
        got.key_index = out_mon.key_index;
        got.held_mask = out_mon.held_mask;
        if (due_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("result %0d: unexpected word pressed=%0b key=%0d held=%04h",
                     results_seen, got.pressed, got.key_index, got.held_mask);
          end
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("result %0d: expected pressed=%0b key=%0d held=%04h,",
                       results_seen, want.pressed, want.key_index, want.held_mask);
              $display("  got pressed=%0b key=%0d held=%04h",
                       got.pressed, got.key_index, got.held_mask);
            end
          end
        end
        results_seen++;
      end
      pending_o = due_results.size();
    end
  end

endmodule

FILE: verif/tb_hex_keypad_press_with_repeat.sv
// Top of the keypad qualifier testbench: clock, reset, bursty stimulus with
// random result stalls, delay register phases and the final verdict.
// Depends on hkp_pkg, hkp_ifs, hkp_keypad_checker and the block itself.
module tb_hex_keypad_press_with_repeat;
  import hkp_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DelayW-1:0]  cfg_data;

  int errors;
  int pending;
  int presses;
  int repeats;

  int          words_sent;
  int          burst_left;
  bit          hold_off_go;
  logic [15:0] held_keys;
  logic [31:0] tick_now;

  hkp_in_if  in_if ();
  hkp_out_if out_if ();

  hex_keypad_press_with_repeat u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  hkp_keypad_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .presses_o  (presses),
    .repeats_o  (repeats)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stretches of full flow, random stalls and heavy stalls, plus one long hold-off.
  initial begin
    int mode;
    int len;
    out_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(5, 40);
      repeat (len) begin
        @(negedge clk_i);
        if (hold_off_go) begin
          hold_off_go = 1'b0;
          out_if.ready <= 1'b0;
          repeat (100) @(negedge clk_i);
        end
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic offer(input logic func, input logic [15:0] raw, input logic [31:0] tick);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.func     <= func;
    in_if.raw_keys <= raw;
    in_if.tick     <= tick;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [DelayW-1:0] first_set[6];
    logic [DelayW-1:0] again_set[6];
    int                r;
    int                k;
    first_set = '{8'd20, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
    again_set = '{8'd5, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = RegInitialDelay;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.func     = FuncSample;
    in_if.raw_keys = '0;
    in_if.tick     = '0;
    hold_off_go    = 1'b0;
    words_sent     = 0;
    burst_left     = 0;
    held_keys      = '0;
    tick_now       = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset state, first press, repeat timing, multi-key lock, wrap.
    offer(FuncPoll,   16'($urandom), 32'd0);
    offer(FuncSample, 16'h0001, $urandom);
    offer(FuncPoll,   16'($urandom), 32'd100);
    offer(FuncSample, 16'h0001, $urandom);
    offer(FuncPoll,   16'($urandom), 32'd110);
    offer(FuncPoll,   16'($urandom), 32'd120);
    offer(FuncPoll,   16'($urandom), 32'd125);
    offer(FuncSample, 16'hFFFF, $urandom);
    offer(FuncPoll,   16'($urandom), 32'd126);
    offer(FuncSample, 16'hFFFF, $urandom);
    offer(FuncPoll,   16'($urandom), 32'hFFFF_FFF0);
    offer(FuncPoll,   16'($urandom), 32'hFFFF_FFFF);
    offer(FuncPoll,   16'($urandom), 32'd2);
    offer(FuncSample, 16'h8000, $urandom);
    offer(FuncPoll,   16'($urandom), 32'd3);
    offer(FuncSample, 16'h0000, $urandom);
    offer(FuncSample, 16'h8000, $urandom);
    offer(FuncPoll,   16'($urandom), 32'h8000_0000);
    offer(FuncSample, 16'h5A5A, $urandom);
    offer(FuncPoll,   16'($urandom), 32'h8000_0001);
    offer(FuncSample, 16'hA5A5, $urandom);
    offer(FuncPoll,   16'($urandom), 32'h8000_0002);
    offer(FuncSample, 16'h0000, $urandom);
    offer(FuncPoll,   16'($urandom), 32'hFFFF_FFFF);

    tick_now = 32'd1000;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        if (p == 5) begin
          first_set[p] = DelayW'($urandom_range(1, 254));
          again_set[p] = DelayW'($urandom_range(1, 254));
        end
        cfg_we   <= 1'b1;
        cfg_idx  <= RegInitialDelay;
        cfg_data <= first_set[p];
        @(negedge clk_i);
        cfg_idx  <= RegRepeatDelay;
        cfg_data <= again_set[p];
        @(negedge clk_i);
        cfg_we <= 1'b0;
        @(negedge clk_i);
      end
      if (p == 0) begin
        hold_off_go = 1'b1;
      end
      repeat (75) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 99) < 45) begin
          if (r < 35) begin
          end else if (r < 60) begin
            held_keys |= 16'(1 << k);
          end else if (r < 70) begin
            held_keys &= ~16'(1 << k);
          end else if (r < 80) begin
            held_keys = '0;
          end else if (r < 90) begin
            held_keys = 16'(1 << k);
          end else begin
            held_keys = 16'($urandom);
          end
          offer(FuncSample, held_keys, $urandom);
        end else begin
          if (r < 60) begin
            tick_now += $urandom_range(0, 12);
          end else if (r < 80) begin
            tick_now += $urandom_range(0, 300);
          end else if (r < 87) begin
          end else if (r < 90) begin
            tick_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
          end else begin
            tick_now = $urandom;
          end
          offer(FuncPoll, 16'($urandom), tick_now);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d words over 6 delay settings, including one long result hold-off.",
             words_sent);
    $display("Keys reported: %0d fresh presses and %0d auto-repeats.", presses, repeats);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
